[hdl/integer_expression_alu_core_macros.svh]
// Assertion macros shared by the checker of the integer expression ALU core.
// Depends on nothing; included by the checker file.
// Include guard below.
`ifndef INTEGER_EXPRESSION_ALU_CORE_MACROS_SVH
`define INTEGER_EXPRESSION_ALU_CORE_MACROS_SVH

// An implication checked at every rising edge outside reset.
`define IEA_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// A condition that must hold in the cycle after the antecedent, reset included.
`define IEA_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/iea_pkg.sv]
// Package of the integer expression ALU core: operation codes and the
// control word that travels down the pipeline. Depends on nothing.
package iea_pkg;

   localparam logic [4:0] OP_PASS   = 5'd0;
   localparam logic [4:0] OP_ADD    = 5'd1;
   localparam logic [4:0] OP_SUB    = 5'd2;
   localparam logic [4:0] OP_MUL    = 5'd3;
   localparam logic [4:0] OP_DIV    = 5'd4;
   localparam logic [4:0] OP_MOD    = 5'd5;
   localparam logic [4:0] OP_AND    = 5'd6;
   localparam logic [4:0] OP_OR     = 5'd7;
   localparam logic [4:0] OP_XOR    = 5'd8;
   localparam logic [4:0] OP_NOT    = 5'd9;
   localparam logic [4:0] OP_LAND   = 5'd10;
   localparam logic [4:0] OP_LOR    = 5'd11;
   localparam logic [4:0] OP_LNOT   = 5'd12;
   localparam logic [4:0] OP_EQ     = 5'd13;
   localparam logic [4:0] OP_NE     = 5'd14;
   localparam logic [4:0] OP_LT     = 5'd15;
   localparam logic [4:0] OP_LE     = 5'd16;
   localparam logic [4:0] OP_GT     = 5'd17;
   localparam logic [4:0] OP_GE     = 5'd18;
   localparam logic [4:0] OP_LSHIFT = 5'd19;
   localparam logic [4:0] OP_RSHIFT = 5'd20;

   typedef struct packed {
      logic valid;
      logic sel_div;
      logic sel_mod;
      logic neg_q;
      logic neg_r;
      logic status;
   } iea_ctl_type;

endpackage

[hdl/iea_front.sv]
// First pipeline stage: decodes the operation, computes every result but the
// quotient and remainder, multiply included, and prepares divider magnitudes. Uses iea_pkg.
module iea_front import iea_pkg::*; #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  logic [4:0]   mode,
   input  logic [W-1:0] operand_a,
   input  logic [W-1:0] operand_b,
   output iea_ctl_type  ctl_o,
   output logic [W-1:0] smp_o,
   output logic [W-1:0] mag_a_o,
   output logic [W-1:0] mag_b_o
);

   localparam int SW = $clog2(W);
   localparam logic [W-1:0] W_LIT = W'(W);

   iea_ctl_type  ctl_ff, ctl_in;
   logic [W-1:0] smp_ff, smp_in;
   logic [W-1:0] mag_a_ff, mag_b_ff;
   logic [W-1:0] mag_a_in, mag_b_in;
   logic         an, bn, a_nz, b_nz, lt, gt, sh_ok;
   logic [SW-1:0] shamt;

   always_comb begin
      an       = operand_a[W-1];
      bn       = operand_b[W-1];
      a_nz     = (operand_a != '0);
      b_nz     = (operand_b != '0);
      lt       = $signed(operand_a) < $signed(operand_b);
      gt       = $signed(operand_b) < $signed(operand_a);
      sh_ok    = !bn && (operand_b < W_LIT);
      shamt    = operand_b[SW-1:0];
      mag_a_in = an ? (W'(0) - operand_a) : operand_a;
      mag_b_in = bn ? (W'(0) - operand_b) : operand_b;
      ctl_in         = '0;
      ctl_in.valid   = in_valid;
      ctl_in.neg_q   = an ^ bn;
      ctl_in.neg_r   = an;
      smp_in         = '0;
      unique case (mode)
         OP_PASS:   smp_in = operand_a;
         OP_ADD:    smp_in = operand_a + operand_b;
         OP_SUB:    smp_in = operand_a - operand_b;
         OP_MUL:    smp_in = W'(operand_a * operand_b);
         OP_DIV: begin
            ctl_in.status  = !b_nz;
            ctl_in.sel_div = b_nz;
         end
         OP_MOD: begin
            ctl_in.status  = !b_nz;
            ctl_in.sel_mod = b_nz;
         end
         OP_AND:    smp_in = operand_a & operand_b;
         OP_OR:     smp_in = operand_a | operand_b;
         OP_XOR:    smp_in = operand_a ^ operand_b;
         OP_NOT:    smp_in = ~operand_a;
         OP_LAND:   smp_in = W'(a_nz && b_nz);
         OP_LOR:    smp_in = W'(a_nz || b_nz);
         OP_LNOT:   smp_in = W'(!a_nz);
         OP_EQ:     smp_in = W'(operand_a == operand_b);
         OP_NE:     smp_in = W'(operand_a != operand_b);
         OP_LT:     smp_in = W'(lt);
         OP_LE:     smp_in = W'(!gt);
         OP_GT:     smp_in = W'(gt);
         OP_GE:     smp_in = W'(!lt);
         OP_LSHIFT: smp_in = sh_ok ? (operand_a << shamt) : '0;
         OP_RSHIFT: smp_in = sh_ok ? W'($signed(operand_a) >>> shamt) : {W{an}};
         default:   smp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
      if (en) begin
         smp_ff   <= smp_in;
         mag_a_ff <= mag_a_in;
         mag_b_ff <= mag_b_in;
      end
   end

   assign ctl_o   = ctl_ff;
   assign smp_o   = smp_ff;
   assign mag_a_o = mag_a_ff;
   assign mag_b_o = mag_b_ff;

endmodule

[hdl/iea_div_step.sv]
// One restoring-division stage: brings in one dividend bit, compares and
// subtracts, and carries the rest of the word along. Uses iea_pkg.
module iea_div_step import iea_pkg::*; #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  iea_ctl_type  ctl_i,
   input  logic [W-1:0] smp_i,
   input  logic [W-1:0] rem_i,
   input  logic [W-1:0] quo_i,
   input  logic [W-1:0] dvs_i,
   output iea_ctl_type  ctl_o,
   output logic [W-1:0] smp_o,
   output logic [W-1:0] rem_o,
   output logic [W-1:0] quo_o,
   output logic [W-1:0] dvs_o
);

   iea_ctl_type  ctl_ff;
   logic [W-1:0] smp_ff, rem_ff, quo_ff, dvs_ff;
   logic [W-1:0] rem_in, quo_in;
   logic [W:0]   trial, diff;
   logic         ge;

   always_comb begin
      trial  = {rem_i, quo_i[W-1]};
      diff   = trial - {1'b0, dvs_i};
      ge     = !diff[W];
      rem_in = ge ? diff[W-1:0] : trial[W-1:0];
      quo_in = {quo_i[W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_i;
      end
      if (en) begin
         smp_ff <= smp_i;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         dvs_ff <= dvs_i;
      end
   end

   assign ctl_o = ctl_ff;
   assign smp_o = smp_ff;
   assign rem_o = rem_ff;
   assign quo_o = quo_ff;
   assign dvs_o = dvs_ff;

endmodule

[hdl/integer_expression_alu_core.sv]
// Integer expression ALU core: a signed ALU pipeline with a divider of
// DATA_WIDTH compare-subtract stages, accepting one word per cycle unless stalled.
// Uses iea_pkg, iea_front and iea_div_step.
//
// Every word passes through the front stage, the DATA_WIDTH divider stages
// and the output register, whatever the operation, since all words follow the
// divider's path of one quotient bit per stage. A new word is taken every
// cycle; the whole pipeline holds when a result waits at the output, so
// req_ready follows rsp_ready whenever the output register is full.
module integer_expression_alu_core import iea_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [4:0]            req_mode,
   input  logic [DATA_WIDTH-1:0] req_operand_a,
   input  logic [DATA_WIDTH-1:0] req_operand_b,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_result_value,
   output logic                  rsp_status
);

   localparam int W = DATA_WIDTH;

   iea_ctl_type  ctl_s [0:W];
   logic [W-1:0] smp_s [0:W];
   logic [W-1:0] rem_s [0:W];
   logic [W-1:0] quo_s [0:W];
   logic [W-1:0] dvs_s [0:W];

   logic         en;
   logic         valid_ff;
   logic [W-1:0] result_ff, result_in;
   logic         status_ff;

   assign en        = !valid_ff || rsp_ready;
   assign req_ready = en;
   assign rem_s[0]  = '0;

   iea_front #(.W(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .mode      (req_mode),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .ctl_o     (ctl_s[0]),
      .smp_o     (smp_s[0]),
      .mag_a_o   (quo_s[0]),
      .mag_b_o   (dvs_s[0])
   );

   for (genvar i = 0; i < W; i++) begin : g_div
      iea_div_step #(.W(W)) u_step (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .ctl_i (ctl_s[i]),
         .smp_i (smp_s[i]),
         .rem_i (rem_s[i]),
         .quo_i (quo_s[i]),
         .dvs_i (dvs_s[i]),
         .ctl_o (ctl_s[i+1]),
         .smp_o (smp_s[i+1]),
         .rem_o (rem_s[i+1]),
         .quo_o (quo_s[i+1]),
         .dvs_o (dvs_s[i+1])
      );
   end

   always_comb begin
      priority if (ctl_s[W].sel_div) begin
         result_in = ctl_s[W].neg_q ? (W'(0) - quo_s[W]) : quo_s[W];
      end else if (ctl_s[W].sel_mod) begin
         result_in = ctl_s[W].neg_r ? (W'(0) - rem_s[W]) : rem_s[W];
      end else begin
         result_in = smp_s[W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= ctl_s[W].valid;
      end
      if (en) begin
         result_ff <= result_in;
         status_ff <= ctl_s[W].status;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_result_value = result_ff;
   assign rsp_status       = status_ff;

endmodule

[hdl/iea_checker.sv]
// Port-level checker for the integer expression ALU core, bound to the top.
// Depends on integer_expression_alu_core_macros.svh.
`include "integer_expression_alu_core_macros.svh"

module iea_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DATA_WIDTH-1:0] rsp_result_value,
   input logic                  rsp_status
);

   `IEA_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid, "Result valid after reset.")
   `IEA_ASSERT_IMPLY(a_zero_div, clock, reset, rsp_valid && rsp_status, rsp_result_value == '0, "Division by zero with a nonzero result.")
   `IEA_ASSERT_IMPLY(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready, "Input taken while the output stalls.")
   `IEA_ASSERT_IMPLY(a_free_ready, clock, reset, !rsp_valid, req_ready, "Input refused with an empty output.")
   `IEA_ASSERT_IMPLY(a_hold, clock, reset, $past(rsp_valid && !rsp_ready) && !$past(reset), rsp_valid && $stable(rsp_result_value), "Stalled word changed.")

endmodule

bind integer_expression_alu_core iea_checker #(.DATA_WIDTH(DATA_WIDTH)) u_iea_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_value (rsp_result_value),
   .rsp_status       (rsp_status)
);
